// ===== sv/kwm_pkg.sv =====
// package: sizes, codes and shared types of the k-way merge engine
`default_nettype none
package kwm_pkg;

  localparam int LISTS    = 8;
  localparam int LIST_LEN = 256;

  localparam int LIST_IDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int OFF_W      = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
  localparam int POS_W      = $clog2(LIST_LEN + 1);
  localparam int ADDR_W     = LIST_IDX_W + OFF_W;
  localparam int RAM_DEPTH  = 1 << ADDR_W;
  localparam int VAL_W      = 32;

  localparam int OP_W     = 2;
  localparam int SEL_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FROM_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_POP_END
  } state_e;

  typedef struct packed {
    logic init;
    logic load;
  } cmp_ctl_t;

  typedef struct packed {
    logic                  found;
    logic [LIST_IDX_W-1:0] idx;
    logic [POS_W-1:0]      pos;
    logic [VAL_W-1:0]      val;
  } best_t;

endpackage
`default_nettype wire

// ===== sv/kwm_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/kwm_best.sv =====
// shared compare unit: keeps the running minimum head over a scan
`default_nettype none
module kwm_best (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kwm_pkg::cmp_ctl_t                ctl_i,
  input  logic [kwm_pkg::LIST_IDX_W-1:0]   idx_i,
  input  logic [kwm_pkg::POS_W-1:0]        pos_i,
  input  logic [kwm_pkg::VAL_W-1:0]        value_i,
  output kwm_pkg::best_t                   best_o
);

  logic                           found_q;
  logic [kwm_pkg::LIST_IDX_W-1:0] idx_q;
  logic [kwm_pkg::POS_W-1:0]      pos_q;
  logic [kwm_pkg::VAL_W-1:0]      val_q;
  logic                           take;

  // ties go to the later (higher) list
  assign take = ctl_i.load && (!found_q || (value_i <= val_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.init) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.init) begin
      idx_q <= idx_i;
      pos_q <= pos_i;
      val_q <= value_i;
    end
  end

  assign best_o.found = found_q;
  assign best_o.idx   = idx_q;
  assign best_o.pos   = pos_q;
  assign best_o.val   = val_q;

endmodule
`default_nettype wire

// ===== sv/kwm_ctrl.sv =====
// sequencer with head and fill pointers, drives the list ram and compare unit
`default_nettype none
module kwm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [kwm_pkg::OP_W-1:0]        op_i,
  input  logic [kwm_pkg::SEL_W-1:0]       list_sel_i,
  input  logic [kwm_pkg::VAL_W-1:0]       value_i,
  output logic                            ram_we_o,
  output logic [kwm_pkg::ADDR_W-1:0]      ram_waddr_o,
  output logic [kwm_pkg::VAL_W-1:0]       ram_wdata_o,
  output logic [kwm_pkg::ADDR_W-1:0]      ram_raddr_o,
  output kwm_pkg::cmp_ctl_t               cmp_ctl_o,
  output logic [kwm_pkg::LIST_IDX_W-1:0]  cmp_idx_o,
  output logic [kwm_pkg::POS_W-1:0]       cmp_pos_o,
  input  kwm_pkg::best_t                  best_i,
  output logic                            done_o,
  output logic [kwm_pkg::STATUS_W-1:0]    status_o,
  output logic [kwm_pkg::VAL_W-1:0]       min_value_o,
  output logic [kwm_pkg::FROM_W-1:0]      from_list_o
);

  localparam logic [kwm_pkg::LIST_IDX_W-1:0] LastIdx =
    kwm_pkg::LIST_IDX_W'(kwm_pkg::LISTS - 1);
  localparam logic [kwm_pkg::POS_W-1:0] FullPos =
    kwm_pkg::POS_W'(kwm_pkg::LIST_LEN);

  kwm_pkg::state_e state_q, state_d;

  logic [kwm_pkg::POS_W-1:0]      head_q [kwm_pkg::LISTS];
  logic [kwm_pkg::POS_W-1:0]      fill_q [kwm_pkg::LISTS];
  logic [kwm_pkg::LIST_IDX_W-1:0] idx_q, idx_d;
  logic [kwm_pkg::OP_W-1:0]       op_q;
  logic                           sel_ok_q;
  logic [kwm_pkg::VAL_W-1:0]      value_q;

  logic                           rd_vld_q;
  logic [kwm_pkg::LIST_IDX_W-1:0] rd_idx_q;
  logic [kwm_pkg::POS_W-1:0]      rd_pos_q;

  logic [kwm_pkg::POS_W-1:0] cur_head;
  logic [kwm_pkg::POS_W-1:0] cur_fill;
  logic                      accept;
  logic                      clr_all;
  logic                      fill_inc;
  logic                      head_inc;
  logic                      issue;
  logic                      issue_vld;

  logic                         done_d;
  logic [kwm_pkg::STATUS_W-1:0] status_d;
  logic [kwm_pkg::VAL_W-1:0]    min_value_d;
  logic [kwm_pkg::FROM_W-1:0]   from_list_d;

  assign busy      = (state_q != kwm_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cur_head  = head_q[idx_q];
  assign cur_fill  = fill_q[idx_q];
  assign issue_vld = cur_head < cur_fill;

  assign ram_waddr_o = {idx_q, cur_fill[kwm_pkg::OFF_W-1:0]};
  assign ram_wdata_o = value_q;
  assign ram_raddr_o = {idx_q, cur_head[kwm_pkg::OFF_W-1:0]};

  assign cmp_ctl_o.init = accept;
  assign cmp_ctl_o.load = rd_vld_q;
  assign cmp_idx_o      = rd_idx_q;
  assign cmp_pos_o      = rd_pos_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    clr_all     = 1'b0;
    fill_inc    = 1'b0;
    head_inc    = 1'b0;
    issue       = 1'b0;
    ram_we_o    = 1'b0;
    done_d      = 1'b0;
    status_d    = kwm_pkg::ST_DONE;
    min_value_d = '0;
    from_list_d = '0;
    case (state_q)
      kwm_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == kwm_pkg::OP_POP) begin
            state_d = kwm_pkg::S_SCAN;
            idx_d   = '0;
          end else begin
            state_d = kwm_pkg::S_EXEC;
            idx_d   = kwm_pkg::LIST_IDX_W'(list_sel_i);
          end
        end
      end
      kwm_pkg::S_EXEC: begin
        state_d = kwm_pkg::S_IDLE;
        done_d  = 1'b1;
        case (op_q)
          kwm_pkg::OP_CLEAR: begin
            clr_all = 1'b1;
          end
          kwm_pkg::OP_APPEND: begin
            if (!sel_ok_q || (cur_fill >= FullPos)) begin
              status_d = kwm_pkg::ST_FULL;
            end else begin
              ram_we_o = 1'b1;
              fill_inc = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      kwm_pkg::S_SCAN: begin
        issue = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = kwm_pkg::S_DRAIN;
        end
      end
      kwm_pkg::S_DRAIN: begin
        state_d = kwm_pkg::S_POP_END;
      end
      kwm_pkg::S_POP_END: begin
        state_d = kwm_pkg::S_IDLE;
        done_d  = 1'b1;
        if (best_i.found) begin
          head_inc    = 1'b1;
          status_d    = kwm_pkg::ST_POPPED;
          min_value_d = best_i.val;
          from_list_d = kwm_pkg::FROM_W'(best_i.idx);
        end else begin
          status_d = kwm_pkg::ST_EMPTY;
        end
      end
      default: begin
        state_d = kwm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kwm_pkg::S_IDLE;
      rd_vld_q <= 1'b0;
      done_o   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue && issue_vld;
      done_o   <= done_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < kwm_pkg::LISTS; k++) begin
        head_q[k] <= '0;
        fill_q[k] <= '0;
      end
    end else if (clr_all) begin
      for (int k = 0; k < kwm_pkg::LISTS; k++) begin
        head_q[k] <= '0;
        fill_q[k] <= '0;
      end
    end else begin
      if (fill_inc) begin
        fill_q[idx_q] <= cur_fill + 1'b1;
      end
      if (head_inc) begin
        head_q[best_i.idx] <= best_i.pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      sel_ok_q <= (32'(list_sel_i) < 32'(kwm_pkg::LISTS));
      value_q  <= value_i;
    end
    rd_idx_q    <= idx_q;
    rd_pos_q    <= cur_head;
    status_o    <= status_d;
    min_value_o <= min_value_d;
    from_list_o <= from_list_d;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in progress");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != kwm_pkg::ST_POPPED)) |->
      ((min_value_o == '0) && (from_list_o == '0)))
    else $error("non-pop result carries nonzero fields");
  a_load_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((state_q == kwm_pkg::S_SCAN) || (state_q == kwm_pkg::S_DRAIN)))
    else $error("compare load outside a pop scan");
`endif

endmodule
`default_nettype wire

// ===== sv/kway_merge_min_select.sv =====
// top level of the k-way merge engine: sequencer, list ram and compare unit
//
//   channel  | handshake           | fields
//   ---------+---------------------+--------------------------------------
//   command  | start, busy         | op_i, list_sel_i, value_i
//   result   | done_o (one cycle)  | status_o, min_value_o, from_list_o
//
// clear and append pass through the execute state before done_o; pop issues one
// list-head ram read per list in turn through the single compare unit, then passes
// through the drain and pop-end states before done_o.
// busy is high from the cycle after the accepting edge through the cycle before done_o.
// reset clears all head and fill pointers at once; the list ram needs no pass.
// done_o is a one-cycle strobe: the receiver cannot stall it.
`default_nettype none
module kway_merge_min_select (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [kwm_pkg::OP_W-1:0]        op_i,
  input  logic [kwm_pkg::SEL_W-1:0]       list_sel_i,
  input  logic [kwm_pkg::VAL_W-1:0]       value_i,
  output logic                            done_o,
  output logic [kwm_pkg::STATUS_W-1:0]    status_o,
  output logic [kwm_pkg::VAL_W-1:0]       min_value_o,
  output logic [kwm_pkg::FROM_W-1:0]      from_list_o
);

  logic                           ram_we;
  logic [kwm_pkg::ADDR_W-1:0]     ram_waddr;
  logic [kwm_pkg::VAL_W-1:0]      ram_wdata;
  logic [kwm_pkg::ADDR_W-1:0]     ram_raddr;
  logic [kwm_pkg::VAL_W-1:0]      ram_rdata;
  kwm_pkg::cmp_ctl_t              cmp_ctl;
  logic [kwm_pkg::LIST_IDX_W-1:0] cmp_idx;
  logic [kwm_pkg::POS_W-1:0]      cmp_pos;
  kwm_pkg::best_t                 best;

  kwm_ram #(
    .WIDTH (kwm_pkg::VAL_W),
    .DEPTH (kwm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kwm_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cmp_ctl),
    .idx_i   (cmp_idx),
    .pos_i   (cmp_pos),
    .value_i (ram_rdata),
    .best_o  (best)
  );

  kwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .list_sel_i  (list_sel_i),
    .value_i     (value_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .cmp_ctl_o   (cmp_ctl),
    .cmp_idx_o   (cmp_idx),
    .cmp_pos_o   (cmp_pos),
    .best_i      (best),
    .done_o      (done_o),
    .status_o    (status_o),
    .min_value_o (min_value_o),
    .from_list_o (from_list_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb_kway_merge_min_select.sv =====
// testbench for the k-way merge engine: random command streams checked against a model
`timescale 1ns / 100ps
module tb_kway_merge_min_select;

  localparam logic [kwm_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int N_ITEMS = 1600;

  typedef struct {
    logic [kwm_pkg::OP_W-1:0]  op;
    logic [kwm_pkg::SEL_W-1:0] sel;
    logic [kwm_pkg::VAL_W-1:0] val;
    int                        gap;
    bit                        drain;
  } merge_cmd_t;

  typedef struct packed {
    logic [kwm_pkg::STATUS_W-1:0] status;
    logic [kwm_pkg::VAL_W-1:0]    min_value;
    logic [kwm_pkg::FROM_W-1:0]   from_list;
  } merge_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [kwm_pkg::OP_W-1:0] op_i = kwm_pkg::OP_CLEAR;
  logic [kwm_pkg::SEL_W-1:0] list_sel_i = '0;
  logic [kwm_pkg::VAL_W-1:0] value_i = '0;
  logic done_o;
  logic [kwm_pkg::STATUS_W-1:0] status_o;
  logic [kwm_pkg::VAL_W-1:0] min_value_o;
  logic [kwm_pkg::FROM_W-1:0] from_list_o;

  kway_merge_min_select dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .list_sel_i  (list_sel_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .min_value_o (min_value_o),
    .from_list_o (from_list_o)
  );

  always #4 clk_i = ~clk_i;

  // model of the list ram and pointers
  logic [kwm_pkg::VAL_W-1:0] list_mem [kwm_pkg::LISTS][kwm_pkg::LIST_LEN];
  int head_ptr [kwm_pkg::LISTS];
  int fill_ptr [kwm_pkg::LISTS];

  merge_cmd_t cmd_q[$];
  merge_res_t expect_q[$];

  // stimulus-side view of the lists
  int gen_fill [kwm_pkg::LISTS];
  logic [kwm_pkg::VAL_W-1:0] gen_last [kwm_pkg::LISTS];
  int gen_live;
  bit quiet;
  bit hold_next;
  int n_cmds;

  int n_sent;
  int n_seen;
  int n_bad;
  int status_seen [4];
  int gap_left;
  bit took;
  merge_cmd_t nxt;
  merge_res_t want;

  function automatic merge_res_t merge_apply(input logic [kwm_pkg::OP_W-1:0] op,
                                             input logic [kwm_pkg::SEL_W-1:0] sel,
                                             input logic [kwm_pkg::VAL_W-1:0] val);
    merge_res_t r;
    logic hit;
    logic [kwm_pkg::VAL_W-1:0] best;
    logic [kwm_pkg::VAL_W-1:0] h;
    int best_k;
    r = '{status: kwm_pkg::ST_DONE, min_value: '0, from_list: '0};
    hit = 1'b0;
    best = '1;
    best_k = 0;
    case (op)
      kwm_pkg::OP_CLEAR: begin
        for (int k = 0; k < kwm_pkg::LISTS; k++) begin
          head_ptr[k] = 0;
          fill_ptr[k] = 0;
        end
      end
      kwm_pkg::OP_APPEND: begin
        if (int'(sel) >= kwm_pkg::LISTS || fill_ptr[sel] >= kwm_pkg::LIST_LEN) begin
          r.status = kwm_pkg::ST_FULL;
        end else begin
          list_mem[sel][fill_ptr[sel]] = val;
          fill_ptr[sel]++;
        end
      end
      kwm_pkg::OP_POP: begin
        for (int k = 0; k < kwm_pkg::LISTS; k++) begin
          if (head_ptr[k] < fill_ptr[k] && head_ptr[k] < kwm_pkg::LIST_LEN) begin
            h = list_mem[k][head_ptr[k]];
            // ties go to the highest list index
            if (!hit || h <= best) begin
              best = h;
              best_k = k;
              hit = 1'b1;
            end
          end
        end
        if (hit) begin
          head_ptr[best_k]++;
          r.status = kwm_pkg::ST_POPPED;
          r.min_value = best;
          r.from_list = best_k[kwm_pkg::FROM_W-1:0];
        end else begin
          r.status = kwm_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic pick_base();
    logic [kwm_pkg::VAL_W-1:0] b;
    case ($urandom_range(0, 3))
      0: b = '0;
      1: b = $urandom();
      2: b = $urandom() >> $urandom_range(0, 31);
      default: b = 32'hFFFF_FFF0;
    endcase
    for (int k = 0; k < kwm_pkg::LISTS; k++) gen_last[k] = b;
  endtask

  function automatic logic [kwm_pkg::VAL_W-1:0] rising_val(input int l);
    logic [kwm_pkg::VAL_W:0] nv;
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) nv = {1'b0, gen_last[l]};
    else if (r < 9) nv = {1'b0, gen_last[l]} + {1'b0, $urandom_range(1, 3)};
    else nv = {1'b0, gen_last[l]} + {1'b0, $urandom_range(0, 1 << 20)};
    return nv[kwm_pkg::VAL_W] ? '1 : nv[kwm_pkg::VAL_W-1:0];
  endfunction

  task automatic push_cmd(input logic [kwm_pkg::OP_W-1:0] op,
                          input logic [kwm_pkg::SEL_W-1:0] sel,
                          input logic [kwm_pkg::VAL_W-1:0] val);
    merge_cmd_t c;
    c.op = op;
    c.sel = sel;
    c.val = val;
    c.gap = quiet ? 0 : $urandom_range(0, 19);
    c.drain = hold_next;
    hold_next = 1'b0;
    cmd_q.push_back(c);
    n_cmds++;
    case (op)
      kwm_pkg::OP_CLEAR: begin
        for (int k = 0; k < kwm_pkg::LISTS; k++) gen_fill[k] = 0;
        gen_live = 0;
        pick_base();
      end
      kwm_pkg::OP_APPEND: begin
        if (gen_fill[sel] < kwm_pkg::LIST_LEN) begin
          gen_fill[sel]++;
          gen_live++;
          gen_last[sel] = val;
        end
      end
      kwm_pkg::OP_POP: if (gen_live > 0) gen_live--;
      default: ;
    endcase
  endtask

  task automatic note_miss(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        expect_q.push_back(merge_apply(op_i, list_sel_i, value_i));
        n_sent++;
        if (cmd_q.size() > 0) gap_left = cmd_q[0].gap;
      end
      if (!start || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && expect_q.size() > 0)) begin
          nxt = cmd_q.pop_front();
          start <= 1'b1;
          op_i <= nxt.op;
          list_sel_i <= nxt.sel;
          value_i <= nxt.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expect_q.size() == 0) begin
        note_miss($sformatf("unexpected result: status %0d value %h list %0d",
                            status_o, min_value_o, from_list_o));
      end else begin
        want = expect_q.pop_front();
        n_seen++;
        status_seen[want.status]++;
        if (status_o !== want.status || min_value_o !== want.min_value ||
            from_list_o !== want.from_list) begin
          note_miss($sformatf(
            "transaction %0d: expected status %0d value %h list %0d, got %0d %h %0d",
            n_seen, want.status, want.min_value, want.from_list,
            status_o, min_value_o, from_list_o));
        end
      end
    end
  end

  initial begin
    int l;
    int pick;
    int bursts;
    bursts = 0;
    pick_base();

    // directed: empty pop, spare op, extremes, ties, unsorted list, drain, clear
    push_cmd(kwm_pkg::OP_POP, '0, '0);
    push_cmd(OP_SPARE, 3'd7, '1);
    push_cmd(kwm_pkg::OP_APPEND, 3'd0, '0);
    push_cmd(kwm_pkg::OP_APPEND, 3'd7, '1);
    push_cmd(kwm_pkg::OP_APPEND, 3'd2, '1);
    push_cmd(kwm_pkg::OP_APPEND, 3'd3, 32'd5);
    push_cmd(kwm_pkg::OP_APPEND, 3'd5, 32'd5);
    push_cmd(kwm_pkg::OP_APPEND, 3'd1, 32'd5);
    push_cmd(kwm_pkg::OP_APPEND, 3'd4, 32'd100);
    push_cmd(kwm_pkg::OP_APPEND, 3'd4, 32'd50);
    push_cmd(kwm_pkg::OP_APPEND, 3'd6, 32'h8000_0000);
    repeat (11) push_cmd(kwm_pkg::OP_POP, '1, '1);
    hold_next = 1'b1;
    push_cmd(kwm_pkg::OP_APPEND, 3'd6, 32'd9);
    push_cmd(kwm_pkg::OP_CLEAR, '0, '0);
    push_cmd(kwm_pkg::OP_POP, '0, '0);

    while (n_cmds < N_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
      if (bursts < 2 && n_cmds > 450 * (bursts + 1)) begin
        // fill one list to the top and push past it
        l = $urandom_range(0, kwm_pkg::LISTS - 1);
        repeat (kwm_pkg::LIST_LEN - gen_fill[l] + $urandom_range(1, 3))
          push_cmd(kwm_pkg::OP_APPEND, l[kwm_pkg::SEL_W-1:0], rising_val(l));
        bursts++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          push_cmd(kwm_pkg::OP_CLEAR, kwm_pkg::SEL_W'($urandom()), $urandom());
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) < 6) begin
              l = $urandom_range(0, kwm_pkg::LISTS - 1);
              push_cmd(kwm_pkg::OP_APPEND, l[kwm_pkg::SEL_W-1:0], rising_val(l));
            end else begin
              push_cmd(kwm_pkg::OP_POP, kwm_pkg::SEL_W'($urandom()), $urandom());
            end
          end
        end else if (pick < 90) begin
          repeat (gen_live + $urandom_range(1, 2))
            push_cmd(kwm_pkg::OP_POP, kwm_pkg::SEL_W'($urandom()), $urandom());
        end else begin
          repeat ($urandom_range(1, 4))
            push_cmd(kwm_pkg::OP_W'($urandom_range(0, 3)),
                     kwm_pkg::SEL_W'($urandom()), $urandom());
        end
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_sent == n_cmds);
    while (expect_q.size() > 0) @(posedge clk_i);
    repeat (kwm_pkg::LISTS + 12) @(posedge clk_i);

    $display("checked %0d transactions: %0d pops with a value, %0d pops on empty lists,",
             n_seen, status_seen[kwm_pkg::ST_POPPED], status_seen[kwm_pkg::ST_EMPTY]);
    $display("%0d appends rejected as full, %0d clears/appends/spare ops, %0d mismatches",
             status_seen[kwm_pkg::ST_FULL], status_seen[kwm_pkg::ST_DONE], n_bad);
    if (n_bad == 0) begin
      $display("kway_merge_min_select test passed");
    end else begin
      $display("kway_merge_min_select test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expect_q.size());
    $display("kway_merge_min_select test failed");
    $finish;
  end

endmodule
